>>> sv/assert_macros.svh
// Assertion macros for checker files, included by rtbc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/rtbc_pkg.sv
`timescale 1ns / 1ps
package rtbc_pkg;

    localparam int unsigned MaxTimeoutUs = 1100000;
    localparam int unsigned MacroVcsel   = 2304;
    localparam int unsigned PhasecalUs   = 1000;
    localparam int unsigned MmUs         = 1;
    localparam int unsigned RoundHalf    = 32'h800;
    localparam int unsigned PllNum       = 32'h4000_0000;
    localparam logic [15:0] GuardReset   = 16'd4528;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_GUARD    = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_ZERO_DIV = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        ACT_ENCODE = 1'b0,
        ACT_DECODE = 1'b1
    } t_action;

    typedef enum logic [0:0] {
        REG_OSC_FREQ = 1'b0,
        REG_GUARD    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        action;
        logic [31:0] req_budget;
        logic [7:0]  vcsel_period_a;
        logic [7:0]  vcsel_period_b;
        logic [15:0] range_code_a;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [7:0]  phasecal_timeout;
        logic [15:0] mm_code_a;
        logic [15:0] range_code_a_out;
        logic [15:0] mm_code_b;
        logic [15:0] range_code_b;
        logic [31:0] budget_out;
    } t_out_word;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage

>>> sv/ranging_timing_budget_converter.sv
`timescale 1ns / 1ps
// Encode runs six divider passes (PLL, phasecal, then mm and range codes for A and B),
//   shifting each timeout code's mantissa until it fits in eight bits; decode runs one (PLL).
// Guard, limit and zero-frequency status end in S_CHECK; a zero macro period (encode) in S_MAC_B2.
// Throughput: one word at a time; busy high until o_done, next word may start on that edge.
// Result strobe o_done lasts one cycle; the receiver cannot stall it.
// Reset (synchronous, active low) clears control state; osc_frequency to 0, guard to 4528.
module ranging_timing_budget_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rtbc_pkg::t_in_word  i_data,
    output logic                o_done,
    output rtbc_pkg::t_out_word o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_PLL, S_MAC_A1, S_MAC_A2, S_MAC_B1, S_MAC_B2,
        S_DIV, S_ENC, S_DEC1, S_DEC2, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_osc, r_guard;
    rtbc_pkg::t_in_word  r_in;
    rtbc_pkg::t_out_word r_out;
    logic        r_done;
    logic [31:0] r_pll, r_ma, r_mb, r_rem, r_acc, r_mant;
    logic [7:0]  r_expo;
    logic [2:0]  r_job;
    logic [63:0] r_prod;
    rtbc_pkg::t_div_req w_req;
    rtbc_pkg::t_div_rsp w_rsp;
    logic        r_dstart;
    logic [31:0] r_dnum, r_dden;
    logic [31:0] w_diff, w_mac, w_dec;
    logic [7:0]  w_pcl;
    logic [15:0] w_code;

    assign w_req.start = r_dstart;
    assign w_req.num   = r_dnum;
    assign w_req.den   = r_dden;

    rtbc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_comb begin
        w_diff = r_in.req_budget - {16'd0, r_guard};
        w_pcl  = (r_state == S_MAC_A1 || r_state == S_MAC_A2) ?
                 8'((r_in.vcsel_period_a + 8'd1) << 1) :
                 8'((r_in.vcsel_period_b + 8'd1) << 1);
        w_mac  = 32'((r_pll * rtbc_pkg::MacroVcsel) >> 6);
        w_dec  = (r_in.range_code_a[15:8] >= 8'd32) ? 32'd0 :
                 ({24'd0, r_in.range_code_a[7:0]} << r_in.range_code_a[12:8]);
        w_code = (r_acc == 32'd0) ? 16'd0 : {r_expo, r_mant[7:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_dstart <= 1'b0;
            r_osc    <= '0;
            r_guard  <= rtbc_pkg::GuardReset;
        end else begin
            r_done   <= 1'b0;
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == rtbc_pkg::REG_OSC_FREQ) r_osc <= i_cfg_data;
                else r_guard <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in    <= i_data;
                        r_out   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_in.action == rtbc_pkg::ACT_ENCODE &&
                        r_in.req_budget <= {16'd0, r_guard}) begin
                        r_out.status <= rtbc_pkg::ST_GUARD;
                        r_state <= S_OUT;
                    end else if (r_in.action == rtbc_pkg::ACT_ENCODE &&
                                 w_diff > rtbc_pkg::MaxTimeoutUs) begin
                        r_out.status <= rtbc_pkg::ST_TOO_BIG;
                        r_state <= S_OUT;
                    end else if (r_osc == 16'd0) begin
                        r_out.status <= rtbc_pkg::ST_ZERO_DIV;
                        r_state <= S_OUT;
                    end else begin
                        r_rem    <= {1'b0, w_diff[31:1]};
                        r_dnum   <= rtbc_pkg::PllNum;
                        r_dden   <= {16'd0, r_osc};
                        r_dstart <= 1'b1;
                        r_state  <= S_PLL;
                    end
                end
                S_PLL: begin
                    if (w_rsp.done) begin
                        r_pll   <= w_rsp.quo;
                        r_state <= S_MAC_A1;
                    end
                end
                S_MAC_A1: begin
                    r_acc   <= w_mac * {24'd0, w_pcl};
                    r_state <= S_MAC_A2;
                end
                S_MAC_A2: begin
                    r_ma <= r_acc >> 6;
                    if (r_in.action == rtbc_pkg::ACT_DECODE) r_state <= S_DEC1;
                    else r_state <= S_MAC_B1;
                end
                S_MAC_B1: begin
                    r_acc   <= w_mac * {24'd0, w_pcl};
                    r_state <= S_MAC_B2;
                end
                S_MAC_B2: begin
                    r_mb  <= r_acc >> 6;
                    r_job <= 3'd0;
                    if (r_ma == 32'd0 || (r_acc >> 6) == 32'd0) begin
                        r_out.status <= rtbc_pkg::ST_ZERO_DIV;
                        r_state <= S_OUT;
                    end else begin
                        r_dnum   <= (32'(rtbc_pkg::PhasecalUs) << 12) + (r_ma >> 1);
                        r_dden   <= r_ma;
                        r_dstart <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_acc  <= w_rsp.quo;
                        r_mant <= w_rsp.quo - 32'd1;
                        r_expo <= '0;
                        if (r_job == 3'd0) begin
                            r_out.phasecal_timeout <=
                                (w_rsp.quo > 32'hFF) ? 8'hFF : w_rsp.quo[7:0];
                            r_job    <= 3'd1;
                            r_dnum   <= (32'(rtbc_pkg::MmUs) << 12) + (r_ma >> 1);
                            r_dden   <= r_ma;
                            r_dstart <= 1'b1;
                        end else begin
                            r_state <= S_ENC;
                        end
                    end
                end
                S_ENC: begin
                    if ((r_mant & 32'hFFFF_FF00) != 32'd0 && r_acc != 32'd0) begin
                        r_mant <= r_mant >> 1;
                        r_expo <= r_expo + 8'd1;
                    end else begin
                        unique case (r_job)
                            3'd1:    r_out.mm_code_a        <= w_code;
                            3'd2:    r_out.range_code_a_out <= w_code;
                            3'd3:    r_out.mm_code_b        <= w_code;
                            default: r_out.range_code_b     <= w_code;
                        endcase
                        if (r_job == 3'd4) begin
                            r_state <= S_OUT;
                        end else begin
                            r_job    <= r_job + 3'd1;
                            r_dnum   <= (((r_job == 3'd2) ? 32'(rtbc_pkg::MmUs) : r_rem) << 12)
                                        + (((r_job >= 3'd2) ? r_mb : r_ma) >> 1);
                            r_dden   <= (r_job >= 3'd2) ? r_mb : r_ma;
                            r_dstart <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_DEC1: begin
                    r_prod  <= {32'd0, w_dec + 32'd1} * {32'd0, r_ma};
                    r_state <= S_DEC2;
                end
                S_DEC2: begin
                    r_out.budget_out <= {r_prod[42:12], 1'b0}
                                        + 32'((r_prod[11:0] + 64'(rtbc_pkg::RoundHalf)) >> 12 << 1)
                                        + {16'd0, r_guard};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_data = r_out;
endmodule

>>> sv/rtbc_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module rtbc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtbc_pkg::t_div_req i_req,
    output rtbc_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_quo, r_den;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sh, w_sub;

    always_comb begin
        w_sh  = {r_rem[31:0], r_quo[31]};
        w_sub = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                if (!w_sub[32]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

>>> sv/rtbc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtbc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input rtbc_pkg::t_out_word o_data
);
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy || $past(start))
    `ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_done && o_data.status != rtbc_pkg::ST_OK, o_data.budget_out == 32'd0 && o_data.mm_code_a == 16'd0)
endmodule

bind ranging_timing_budget_converter rtbc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_data(o_data)
);
